// ===== hw/rtl/rti_pkg.sv =====
package rti_pkg;

   localparam int COORD_BITS = 20;
   localparam int FRAC_BITS  = 8;

   localparam int CW  = COORD_BITS;
   localparam int EW  = CW + 1;          // edge and offset vectors
   localparam int PW  = 2 * CW + 2;      // P = D x E2
   localparam int QW  = 2 * CW + 3;      // Q = S x E1
   localparam int MW  = QW + EW;         // one term of a dot product
   localparam int NW  = 3 * CW + 8;      // divisor and numerators
   localparam int HB  = NW / 2;          // split point of the divisor for the window products
   localparam int TW  = 32;              // distance width
   localparam int RW  = NW + TW;         // wide compare and remainder width
   localparam int QB  = 32;              // quotient bits produced by the divider
   localparam int BW  = 17;              // weight width
   localparam int VW  = 3 * CW;          // packed vertex width
   localparam int SCALE_SH = 16;         // 1.0 in Q.16

   localparam logic [1:0] CSR_VERTEX_A = 2'd0;
   localparam logic [1:0] CSR_VERTEX_B = 2'd1;
   localparam logic [1:0] CSR_VERTEX_C = 2'd2;

   typedef enum logic [2:0] {
      OUT_HIT      = 3'd0,
      OUT_PARALLEL = 3'd1,
      OUT_U_OUT    = 3'd2,
      OUT_V_OUT    = 3'd3,
      OUT_T_OUT    = 3'd4
   } outcome_type;

   typedef logic [2:0][RW-1:0] rem_vec_type;
   typedef logic [2:0][QB-1:0] quo_vec_type;

endpackage

// ===== hw/rtl/rti_div.sv =====
module rti_div (
   input  logic                  clock,
   input  logic                  en,
   input  logic [rti_pkg::NW-1:0] det_in,
   input  rti_pkg::rem_vec_type  rem_in,
   output rti_pkg::quo_vec_type  quo_out
);

   localparam int NW = rti_pkg::NW;
   localparam int RW = rti_pkg::RW;
   localparam int QB = rti_pkg::QB;

   logic [NW-1:0]        det_ff [QB];
   rti_pkg::rem_vec_type rem_ff [QB];
   rti_pkg::quo_vec_type quo_ff [QB];

   // one quotient bit per stage, most significant first, three lanes share the divisor
   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [NW-1:0]        det_prev;
      rti_pkg::rem_vec_type rem_prev;
      rti_pkg::quo_vec_type quo_prev;
      rti_pkg::rem_vec_type rem_in_v;
      rti_pkg::quo_vec_type quo_in_v;
      logic [RW-1:0]        dsh;

      if (k == 0) begin : g_first
         assign det_prev = det_in;
         assign rem_prev = rem_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign det_prev = det_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign dsh = RW'(det_prev) << (QB - 1 - k);

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (rem_prev[l] >= dsh) begin
               rem_in_v[l] = rem_prev[l] - dsh;
               quo_in_v[l] = {quo_prev[l][QB-2:0], 1'b1};
            end else begin
               rem_in_v[l] = rem_prev[l];
               quo_in_v[l] = {quo_prev[l][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            det_ff[k] <= det_prev;
            rem_ff[k] <= rem_in_v;
            quo_ff[k] <= quo_in_v;
         end
      end
   end

   assign quo_out = quo_ff[QB-1];

endmodule

// ===== hw/rtl/ray_triangle_intersect.sv =====
// Ray / triangle intersection test, one ray per cycle unless the output stalls.
// Load the three vertices through the csr_ port (index 0, 1, 2, x/y/z packed
// from bit 0 upward, 20 bits each) while no ray is in flight.
// Request channel: origin, direction and the [t_min, t_max] window of a ray,
// taken when req_valid is high and req_stall is low.
// Response channel: outcome code, hit distance and two barycentric weights,
// taken when rsp_valid is high and rsp_stall is low. Distance and weights
// read zero unless the outcome is a hit.
// The pipeline has 8 stages of vector arithmetic and window compares,
// 32 stages of a bit-per-stage restoring divider, and the output register.
// Throughput is one ray per cycle when no response is stalled; the divider is most of the depth.
// While the response register holds a result that is stalled, the whole
// pipeline holds and req_stall is raised; nothing is dropped or repeated.
// Reset clears the vertices to zero and empties the pipeline.
module ray_triangle_intersect (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [59:0]         csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [19:0]  req_origin_x,
   input  logic signed [19:0]  req_origin_y,
   input  logic signed [19:0]  req_origin_z,
   input  logic signed [19:0]  req_dir_x,
   input  logic signed [19:0]  req_dir_y,
   input  logic signed [19:0]  req_dir_z,
   input  logic signed [31:0]  req_t_min,
   input  logic signed [31:0]  req_t_max,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_outcome,
   output logic signed [31:0]  rsp_t_hit,
   output logic [16:0]         rsp_bary_u,
   output logic [16:0]         rsp_bary_v
);

   localparam int CW = rti_pkg::CW;
   localparam int EW = rti_pkg::EW;
   localparam int PW = rti_pkg::PW;
   localparam int QW = rti_pkg::QW;
   localparam int MW = rti_pkg::MW;
   localparam int NW = rti_pkg::NW;
   localparam int HB = rti_pkg::HB;
   localparam int TW = rti_pkg::TW;
   localparam int RW = rti_pkg::RW;
   localparam int QB = rti_pkg::QB;
   localparam int BW = rti_pkg::BW;
   localparam int VW = rti_pkg::VW;
   localparam int SH = rti_pkg::SCALE_SH;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // vertex registers
   logic [VW-1:0] va_ff, vb_ff, vc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vb_ff <= '0;
         vc_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            rti_pkg::CSR_VERTEX_A: va_ff <= csr_wr_data[VW-1:0];
            rti_pkg::CSR_VERTEX_B: vb_ff <= csr_wr_data[VW-1:0];
            rti_pkg::CSR_VERTEX_C: vc_ff <= csr_wr_data[VW-1:0];
            default: ;
         endcase
      end
   end

   // valid bits of stages 1..8
   logic [8:1] v_ff;

   // stage 1: edges and origin offset
   logic signed [CW-1:0] d1_ff  [3];
   logic signed [EW-1:0] e1_1_ff [3], e2_1_ff [3], s1_ff [3];
   logic signed [TW-1:0] tmin1_ff, tmax1_ff;

   logic signed [CW-1:0] a_c [3], b_c [3], c_c [3], o_c [3], d_c [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_c[k] = va_ff[k*CW +: CW];
         b_c[k] = vb_ff[k*CW +: CW];
         c_c[k] = vc_ff[k*CW +: CW];
      end
      o_c[0] = req_origin_x[CW-1:0];
      o_c[1] = req_origin_y[CW-1:0];
      o_c[2] = req_origin_z[CW-1:0];
      d_c[0] = req_dir_x[CW-1:0];
      d_c[1] = req_dir_y[CW-1:0];
      d_c[2] = req_dir_z[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            d1_ff[k]   <= d_c[k];
            e1_1_ff[k] <= EW'(b_c[k]) - EW'(a_c[k]);
            e2_1_ff[k] <= EW'(c_c[k]) - EW'(a_c[k]);
            s1_ff[k]   <= EW'(o_c[k]) - EW'(a_c[k]);
         end
         tmin1_ff <= req_t_min;
         tmax1_ff <= req_t_max;
      end
   end

   // stage 2: cross product terms
   logic signed [CW-1:0]   d2_ff  [3];
   logic signed [EW-1:0]   e1_2_ff [3], e2_2_ff [3], s2_ff [3];
   logic signed [TW-1:0]   tmin2_ff, tmax2_ff;
   logic signed [2*CW:0]   pa2_ff [3], pb2_ff [3];
   logic signed [2*EW-1:0] qa2_ff [3], qb2_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pa2_ff[k] <= (2*CW+1)'(d1_ff[(k+1)%3]) * (2*CW+1)'(e2_1_ff[(k+2)%3]);
            pb2_ff[k] <= (2*CW+1)'(d1_ff[(k+2)%3]) * (2*CW+1)'(e2_1_ff[(k+1)%3]);
            qa2_ff[k] <= (2*EW)'(s1_ff[(k+1)%3]) * (2*EW)'(e1_1_ff[(k+2)%3]);
            qb2_ff[k] <= (2*EW)'(s1_ff[(k+2)%3]) * (2*EW)'(e1_1_ff[(k+1)%3]);
         end
         d2_ff    <= d1_ff;
         e1_2_ff  <= e1_1_ff;
         e2_2_ff  <= e2_1_ff;
         s2_ff    <= s1_ff;
         tmin2_ff <= tmin1_ff;
         tmax2_ff <= tmax1_ff;
      end
   end

   // stage 3: P and Q
   logic signed [CW-1:0] d3_ff  [3];
   logic signed [EW-1:0] e1_3_ff [3], e2_3_ff [3], s3_ff [3];
   logic signed [TW-1:0] tmin3_ff, tmax3_ff;
   logic signed [PW-1:0] p3_ff [3];
   logic signed [QW-1:0] q3_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            p3_ff[k] <= PW'(pa2_ff[k]) - PW'(pb2_ff[k]);
            q3_ff[k] <= QW'(qa2_ff[k]) - QW'(qb2_ff[k]);
         end
         d3_ff    <= d2_ff;
         e1_3_ff  <= e1_2_ff;
         e2_3_ff  <= e2_2_ff;
         s3_ff    <= s2_ff;
         tmin3_ff <= tmin2_ff;
         tmax3_ff <= tmax2_ff;
      end
   end

   // stage 4: dot product terms
   logic signed [MW-1:0] dt4_ff [3], ut4_ff [3], vt4_ff [3], tt4_ff [3];
   logic signed [TW-1:0] tmin4_ff, tmax4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            dt4_ff[k] <= MW'(p3_ff[k]) * MW'(e1_3_ff[k]);
            ut4_ff[k] <= MW'(s3_ff[k]) * MW'(p3_ff[k]);
            vt4_ff[k] <= MW'(d3_ff[k]) * MW'(q3_ff[k]);
            tt4_ff[k] <= MW'(e2_3_ff[k]) * MW'(q3_ff[k]);
         end
         tmin4_ff <= tmin3_ff;
         tmax4_ff <= tmax3_ff;
      end
   end

   // stage 5: divisor and numerators
   logic signed [NW-1:0] det5_ff, nu5_ff, nv5_ff, nt5_ff;
   logic signed [TW-1:0] tmin5_ff, tmax5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         det5_ff  <= NW'(dt4_ff[0]) + NW'(dt4_ff[1]) + NW'(dt4_ff[2]);
         nu5_ff   <= NW'(ut4_ff[0]) + NW'(ut4_ff[1]) + NW'(ut4_ff[2]);
         nv5_ff   <= NW'(vt4_ff[0]) + NW'(vt4_ff[1]) + NW'(vt4_ff[2]);
         nt5_ff   <= NW'(tt4_ff[0]) + NW'(tt4_ff[1]) + NW'(tt4_ff[2]);
         tmin5_ff <= tmin4_ff;
         tmax5_ff <= tmax4_ff;
      end
   end

   // stage 6: flag a zero divisor and make the divisor positive
   logic signed [NW-1:0] det6_ff, nu6_ff, nv6_ff, nt6_ff;
   logic signed [TW-1:0] tmin6_ff, tmax6_ff;
   logic                 par6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         par6_ff <= (det5_ff == '0);
         if (det5_ff[NW-1]) begin
            det6_ff <= -det5_ff;
            nu6_ff  <= -nu5_ff;
            nv6_ff  <= -nv5_ff;
            nt6_ff  <= -nt5_ff;
         end else begin
            det6_ff <= det5_ff;
            nu6_ff  <= nu5_ff;
            nv6_ff  <= nv5_ff;
            nt6_ff  <= nt5_ff;
         end
         tmin6_ff <= tmin5_ff;
         tmax6_ff <= tmax5_ff;
      end
   end

   // stage 7: weight tests and split products for the window
   logic signed [NW-1:0]      det7_ff, nu7_ff, nv7_ff, nt7_ff;
   logic signed [HB+TW:0]     plo_min7_ff, plo_max7_ff;
   logic signed [NW-HB+TW-1:0] phi_min7_ff, phi_max7_ff;
   rti_pkg::outcome_type      pre7_ff;
   logic                      chk7_ff;

   logic signed [HB:0]        dlo_c;
   logic signed [NW-HB-1:0]   dhi_c;
   logic signed [NW:0]        uv_sum_c;
   rti_pkg::outcome_type      pre_c;

   always_comb begin
      dlo_c    = {1'b0, det6_ff[HB-1:0]};
      dhi_c    = det6_ff[NW-1:HB];
      uv_sum_c = (NW+1)'(nu6_ff) + (NW+1)'(nv6_ff);
      if (par6_ff)
         pre_c = rti_pkg::OUT_PARALLEL;
      else if (nu6_ff[NW-1] || nu6_ff > det6_ff)
         pre_c = rti_pkg::OUT_U_OUT;
      else if (nv6_ff[NW-1] || uv_sum_c > (NW+1)'(det6_ff))
         pre_c = rti_pkg::OUT_V_OUT;
      else
         pre_c = rti_pkg::OUT_HIT;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_min7_ff <= (HB+TW+1)'(dlo_c) * (HB+TW+1)'(tmin6_ff);
         plo_max7_ff <= (HB+TW+1)'(dlo_c) * (HB+TW+1)'(tmax6_ff);
         phi_min7_ff <= (NW-HB+TW)'(dhi_c) * (NW-HB+TW)'(tmin6_ff);
         phi_max7_ff <= (NW-HB+TW)'(dhi_c) * (NW-HB+TW)'(tmax6_ff);
         det7_ff     <= det6_ff;
         nu7_ff      <= nu6_ff;
         nv7_ff      <= nv6_ff;
         nt7_ff      <= nt6_ff;
         pre7_ff     <= pre_c;
      end
   end

   // stage 8: distance window test and divider operands
   logic [NW-1:0]        det8_ff;
   rti_pkg::rem_vec_type rem8_ff;
   rti_pkg::outcome_type out8_ff;
   logic                 tneg8_ff;

   logic signed [RW-1:0] lim_c, wmin_c, wmax_c;
   rti_pkg::outcome_type out_c;

   always_comb begin
      lim_c  = RW'(nt7_ff) <<< SH;
      wmin_c = RW'(plo_min7_ff) + (RW'(phi_min7_ff) <<< HB);
      wmax_c = RW'(plo_max7_ff) + (RW'(phi_max7_ff) <<< HB);
      if (pre7_ff != rti_pkg::OUT_HIT)
         out_c = pre7_ff;
      else if (lim_c < wmin_c || lim_c > wmax_c)
         out_c = rti_pkg::OUT_T_OUT;
      else
         out_c = rti_pkg::OUT_HIT;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det8_ff    <= det7_ff;
         rem8_ff[0] <= lim_c[RW-1] ? -lim_c : lim_c;
         rem8_ff[1] <= RW'(nu7_ff) << SH;
         rem8_ff[2] <= RW'(nv7_ff) << SH;
         out8_ff    <= out_c;
         tneg8_ff   <= lim_c[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= '0;
      else if (en)
         v_ff <= {v_ff[7:1], req_valid};
   end

   // divider and its side band
   rti_pkg::quo_vec_type quo_c;

   rti_div u_div (
      .clock   (clock),
      .en      (en),
      .det_in  (det8_ff),
      .rem_in  (rem8_ff),
      .quo_out (quo_c)
   );

   logic                 dv_ff    [QB];
   rti_pkg::outcome_type dout_ff  [QB];
   logic                 dtneg_ff [QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QB; k++)
            dv_ff[k] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v_ff[8];
         for (int k = 1; k < QB; k++)
            dv_ff[k] <= dv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dout_ff[0]  <= out8_ff;
         dtneg_ff[0] <= tneg8_ff;
         for (int k = 1; k < QB; k++) begin
            dout_ff[k]  <= dout_ff[k-1];
            dtneg_ff[k] <= dtneg_ff[k-1];
         end
      end
   end

   // response register
   logic                 rsp_valid_ff;
   logic [2:0]           outcome_ff;
   logic signed [TW-1:0] t_hit_ff;
   logic [BW-1:0]        bu_ff, bv_ff;
   logic                 hit_c;

   assign hit_c = (dout_ff[QB-1] == rti_pkg::OUT_HIT);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (en)
         rsp_valid_ff <= dv_ff[QB-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         outcome_ff <= dout_ff[QB-1];
         if (hit_c) begin
            t_hit_ff <= dtneg_ff[QB-1] ? -TW'(quo_c[0]) : TW'(quo_c[0]);
            bu_ff    <= quo_c[1][BW-1:0];
            bv_ff    <= quo_c[2][BW-1:0];
         end else begin
            t_hit_ff <= '0;
            bu_ff    <= '0;
            bv_ff    <= '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = outcome_ff;
   assign rsp_t_hit   = t_hit_ff;
   assign rsp_bary_u  = bu_ff;
   assign rsp_bary_v  = bv_ff;

endmodule

// ===== hw/rtl/rti_chk.sv =====
module rti_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_outcome,
   input logic signed [31:0] rsp_t_hit,
   input logic [16:0]        rsp_bary_u,
   input logic [16:0]        rsp_bary_v
);

   // anything but a hit carries zero distance and weights
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != rti_pkg::OUT_HIT |->
         rsp_t_hit == 32'sd0 && rsp_bary_u == 17'd0 && rsp_bary_v == 17'd0)
      else $error("miss with nonzero payload");

   // weights of a hit stay inside the triangle
   a_bary_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == rti_pkg::OUT_HIT |->
         18'(rsp_bary_u) + 18'(rsp_bary_v) <= 18'd65536)
      else $error("weights sum above one");

   // the request side only holds off when a result is stuck at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome) && $stable(rsp_t_hit))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ray_triangle_intersect rti_chk u_rti_chk (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      logic signed [19:0] ox, oy, oz, dx, dy, dz;
      logic signed [31:0] tmin, tmax;
   } ray_type;

   typedef struct packed {
      rti_pkg::outcome_type outcome;
      logic signed [31:0]   t_hit;
      logic [16:0]          u, v;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = rti_pkg::CSR_VERTEX_A;
   logic [59:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   ray_type req = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_outcome;
   logic signed [31:0] rsp_t_hit;
   logic [16:0] rsp_bary_u, rsp_bary_v;

   logic [59:0] vert_a = '0, vert_b = '0, vert_c = '0;
   hit_type expected_hits[$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int errors = 0, n_rays = 0, n_hits = 0, n_checked = 0;
   longint cycles = 0;

   always #4 clock = ~clock;

   ray_triangle_intersect i_dut (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wr_data,
      .req_valid, .req_stall,
      .req_origin_x(req.ox), .req_origin_y(req.oy), .req_origin_z(req.oz),
      .req_dir_x(req.dx), .req_dir_y(req.dy), .req_dir_z(req.dz),
      .req_t_min(req.tmin), .req_t_max(req.tmax),
      .rsp_valid, .rsp_stall, .rsp_outcome, .rsp_t_hit, .rsp_bary_u, .rsp_bary_v
   );

   function automatic logic signed [19:0] coord(logic [59:0] r, int k);
      return r[k*20 +: 20];
   endfunction

   // Exact intersection arithmetic in 160-bit signed integers.
   function automatic hit_type ray_predict(ray_type r);
      logic signed [159:0] a[3], b[3], c[3], o[3], d[3], e1[3], e2[3], s[3];
      logic signed [159:0] p[3], q[3], det, nu, nv, nt, lim, th;
      hit_type h;
      for (int k = 0; k < 3; k++) begin
         a[k] = coord(vert_a, k);
         b[k] = coord(vert_b, k);
         c[k] = coord(vert_c, k);
      end
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      for (int k = 0; k < 3; k++) begin
         e1[k] = b[k] - a[k];
         e2[k] = c[k] - a[k];
         s[k] = o[k] - a[k];
      end
      p[0] = d[1]*e2[2] - d[2]*e2[1];
      p[1] = d[2]*e2[0] - d[0]*e2[2];
      p[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
      nu = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
      nv = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
      nt = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      h = '0;
      h.outcome = rti_pkg::OUT_HIT;
      if (det == 0) begin
         h.outcome = rti_pkg::OUT_PARALLEL;
         return h;
      end
      if (det < 0) begin
         det = -det; nu = -nu; nv = -nv; nt = -nt;
      end
      lim = nt * 65536;
      if (nu < 0 || nu > det) h.outcome = rti_pkg::OUT_U_OUT;
      else if (nv < 0 || nu + nv > det) h.outcome = rti_pkg::OUT_V_OUT;
      else if (lim < det * $signed(160'(r.tmin)) || lim > det * $signed(160'(r.tmax)))
         h.outcome = rti_pkg::OUT_T_OUT;
      else begin
         th = lim / det;   // truncates toward zero
         if (th > 160'sd2147483647) h.t_hit = 32'h7fffffff;
         else if (th < -160'sd2147483648) h.t_hit = 32'h80000000;
         else h.t_hit = th[31:0];
         h.u = 17'((nu * 65536) / det);
         h.v = 17'((nv * 65536) / det);
      end
      return h;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd3000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset)
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin
      hit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result, outcome %0d", rsp_outcome);
            errors++;
         end else begin
            want = expected_hits.pop_front();
            n_checked++;
            if (rsp_outcome != want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_outcome);
               errors++;
            end
            if (rsp_t_hit !== want.t_hit) begin
               $error("t_hit: expected %0d, got %0d", want.t_hit, rsp_t_hit);
               errors++;
            end
            if (rsp_bary_u !== want.u) begin
               $error("bary_u: expected %0d, got %0d", want.u, rsp_bary_u);
               errors++;
            end
            if (rsp_bary_v !== want.v) begin
               $error("bary_v: expected %0d, got %0d", want.v, rsp_bary_v);
               errors++;
            end
         end
      end
   end

   // valid stays high after a transfer so the next ray can follow directly
   task automatic send_ray(ray_type r);
      hit_type h;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      h = ray_predict(r);
      expected_hits.push_back(h);
      n_rays++;
      if (h.outcome == rti_pkg::OUT_HIT) n_hits++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_vertex(logic [1:0] idx, logic [59:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         rti_pkg::CSR_VERTEX_A: vert_a = val;
         rti_pkg::CSR_VERTEX_B: vert_b = val;
         default:               vert_c = val;
      endcase
   endtask

   function automatic logic [59:0] pack(int x, int y, int z);
      return {20'(z), 20'(y), 20'(x)};
   endfunction

   function automatic ray_type make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                        int tmin, int tmax);
      ray_type r;
      r.ox = 20'(ox); r.oy = 20'(oy); r.oz = 20'(oz);
      r.dx = 20'(dx); r.dy = 20'(dy); r.dz = 20'(dz);
      r.tmin = tmin; r.tmax = tmax;
      return r;
   endfunction

   function automatic int rnd_signed(int bits);
      return int'($urandom) >>> (32 - bits);
   endfunction

   // Random triangle, each coordinate a signed number of span bits.
   task automatic set_triangle(int span);
      write_vertex(rti_pkg::CSR_VERTEX_A,
                   pack(rnd_signed(span), rnd_signed(span), rnd_signed(span)));
      write_vertex(rti_pkg::CSR_VERTEX_B,
                   pack(rnd_signed(span), rnd_signed(span), rnd_signed(span)));
      write_vertex(rti_pkg::CSR_VERTEX_C,
                   pack(rnd_signed(span), rnd_signed(span), rnd_signed(span)));
   endtask

   task automatic test_directed();
      // Unit triangle in z = 0, 1.0 = 256.
      drain();
      write_vertex(rti_pkg::CSR_VERTEX_A, pack(0, 0, 0));
      write_vertex(rti_pkg::CSR_VERTEX_B, pack(256, 0, 0));
      write_vertex(rti_pkg::CSR_VERTEX_C, pack(0, 256, 0));
      send_ray(make_ray(64, 64, 256, 0, 0, -256, 0, 32'h7fffffff));    // hit
      send_ray(make_ray(0, 0, 256, 0, 0, -256, 0, 32'h7fffffff));      // vertex a
      send_ray(make_ray(256, 0, 256, 0, 0, -256, 0, 32'h7fffffff));    // vertex b
      send_ray(make_ray(0, 256, 256, 0, 0, -256, 0, 32'h7fffffff));    // vertex c
      send_ray(make_ray(64, 64, 256, 256, 0, 0, 0, 32'h7fffffff));     // parallel
      send_ray(make_ray(-64, 64, 256, 0, 0, -256, 0, 32'h7fffffff));   // u negative
      send_ray(make_ray(64, -64, 256, 0, 0, -256, 0, 32'h7fffffff));   // v negative
      send_ray(make_ray(200, 200, 256, 0, 0, -256, 0, 32'h7fffffff));  // u + v over
      send_ray(make_ray(64, 64, 256, 0, 0, -256, 0, 65535));           // t beyond window
      send_ray(make_ray(64, 64, 256, 0, 0, -256, 65537, 32'h7fffffff));
      send_ray(make_ray(64, 64, 256, 0, 0, -256, 65536, 65536));       // exact edge
      send_ray(make_ray(64, 64, 256, 0, 0, -256, 70000, 60000));       // empty window
      send_ray(make_ray(64, 64, -256, 0, 0, -256, 32'h80000000, 0));   // behind origin
      send_ray(make_ray(64, 64, 256, 0, 0, 256, 32'h80000000, 32'h7fffffff)); // det < 0
      send_ray(make_ray(64, 64, 256, 0, 0, -1, 0, 32'h7fffffff));      // huge t
      send_ray(make_ray(-524288, 524287, 524287, -524288, 524287, -524288,
                        32'h80000000, 32'h7fffffff));
      send_ray(make_ray(524287, -524288, -524288, 524287, -524288, 524287,
                        32'h80000000, 32'h7fffffff));
      drain();
      // Extreme vertices, then a degenerate (collinear) triangle.
      write_vertex(rti_pkg::CSR_VERTEX_A, {20'h80000, 20'h7ffff, 20'h80000});
      write_vertex(rti_pkg::CSR_VERTEX_B, {20'h7ffff, 20'h80000, 20'h7ffff});
      write_vertex(rti_pkg::CSR_VERTEX_C, 60'hfffff_fffff_fffff);
      send_ray(make_ray(0, 0, 0, 524287, 524287, 524287, 32'h80000000, 32'h7fffffff));
      send_ray(make_ray(-524288, -524288, 524287, -524288, 524287, -524288,
                        32'h80000000, 32'h7fffffff));
      drain();
      write_vertex(rti_pkg::CSR_VERTEX_A, pack(0, 0, 0));
      write_vertex(rti_pkg::CSR_VERTEX_B, pack(100, 100, 100));
      write_vertex(rti_pkg::CSR_VERTEX_C, pack(200, 200, 200));
      send_ray(make_ray(5, 9, 300, 3, 1, -256, 32'h80000000, 32'h7fffffff));
      drain();
   endtask

   task automatic test_random(int count);
      int bits, ox, oy, oz;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            drain();
            bits = (i % 700 == 0) ? 20 : $urandom_range(16, 6);
            set_triangle(bits);
         end
         if ($urandom_range(9) < 8) begin
            // Aim near the triangle from nearby, using vertex midpoints plus a random offset.
            ox = rnd_signed(bits + 1);
            oy = rnd_signed(bits + 1);
            oz = rnd_signed(bits + 1);
            send_ray(make_ray(ox, oy, oz, (coord(vert_a, 0) + coord(vert_b, 0)) / 2 - ox
                              + rnd_signed(bits - 2),
                              (coord(vert_a, 1) + coord(vert_c, 1)) / 2 - oy
                              + rnd_signed(bits - 2),
                              (coord(vert_b, 2) + coord(vert_c, 2)) / 2 - oz
                              + rnd_signed(bits - 2),
                              ($urandom_range(3) == 0) ? int'($urandom) : -$urandom_range(65536),
                              ($urandom_range(3) == 0) ? int'($urandom)
                                                      : $urandom_range(200000, 0)));
         end else begin
            send_ray(make_ray(rnd_signed(20), rnd_signed(20), rnd_signed(20), rnd_signed(20),
                              rnd_signed(20), rnd_signed(20), int'($urandom), int'($urandom)));
         end
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 9; recv_idle_pct = 45;
      test_directed();
      test_random(700);
      send_idle_pct = 45; recv_idle_pct = 9;
      test_random(700);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(700);
      $display("Sent %0d rays over many triangles, %0d hits; %0d results compared.",
               n_rays, n_hits, n_checked);
      if (errors == 0 && expected_hits.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
